// File: design/mfa_pkg.sv
// Package: format constants and the shared field width for the minifloat adder.
package mfa_pkg;
  localparam int unsigned EXP_W_DEF  = 8;
  localparam int unsigned FRAC_W_DEF = 13;
  localparam int unsigned FIELD_W    = 22;
endpackage

// File: design/mfa_align.sv
// Stage 1: unpack, special cases, order by magnitude, align smaller operand.
module mfa_align import mfa_pkg::*; #(
  parameter int unsigned EXP_W  = EXP_W_DEF,
  parameter int unsigned FRAC_W = FRAC_W_DEF,
  localparam int unsigned SW = FRAC_W + 4,
  localparam int unsigned EW = (EXP_W + 2 > $clog2(SW) + 1) ? EXP_W + 2 : $clog2(SW) + 1
) (
  input  logic [FIELD_W-1:0] a_i,
  input  logic [FIELD_W-1:0] b_i,
  output logic               spec_o,
  output logic [FIELD_W-1:0] spec_val_o,
  output logic               sub_o,
  output logic               sign_o,
  output logic [EW-1:0]      ex_o,
  output logic [SW-1:0]      xs_o,
  output logic [SW-1:0]      ys_o
);
  localparam int unsigned FMT = 1 + EXP_W + FRAC_W;
  localparam int unsigned FW  = (FMT > FIELD_W) ? FMT : FIELD_W;
  logic [FW-1:0] aw, bw, qnan, ainf, binf, spec_full;
  logic [EXP_W-1:0] ea, eb;
  logic [FRAC_W-1:0] fa, fb;
  logic sa, sb, za, zb, ia, ib, na, nb, swap;
  logic [EXP_W-1:0] exa, exb, exx, exy, de;
  logic [FRAC_W:0] siga, sigb, sx, sy;
  logic [SW-1:0] yss, lostm;
  logic [FW-1:0] ones;

  always_comb begin
    ones = '0;
    ones[FMT-1:0] = '1;
    aw = FW'(a_i) & ones;
    bw = FW'(b_i) & ones;
    ea = aw[FRAC_W +: EXP_W];
    eb = bw[FRAC_W +: EXP_W];
    fa = aw[FRAC_W-1:0];
    fb = bw[FRAC_W-1:0];
    sa = aw[FMT-1];
    sb = bw[FMT-1];
    za = (ea == '0) && (fa == '0);
    zb = (eb == '0) && (fb == '0);
    ia = (ea == '1) && (fa == '0);
    ib = (eb == '1) && (fb == '0);
    na = (ea == '1) && (fa != '0);
    nb = (eb == '1) && (fb != '0);
    exa = (ea == '0) ? EXP_W'(1) : ea;
    exb = (eb == '0) ? EXP_W'(1) : eb;
    siga = {(ea != '0), fa};
    sigb = {(eb != '0), fb};
    qnan = '0;
    qnan[FRAC_W +: EXP_W] = '1;
    qnan[FRAC_W-1] = 1'b1;
    ainf = '0;
    ainf[FRAC_W +: EXP_W] = '1;
    ainf[FMT-1] = sa;
    binf = ainf;
    binf[FMT-1] = sb;
    spec_o = 1'b1;
    if (na || nb || (ia && ib && (sa != sb))) spec_full = qnan;
    else if (ia) spec_full = ainf;
    else if (ib) spec_full = binf;
    else if (za) spec_full = bw;
    else if (zb) spec_full = aw;
    else begin
      spec_full = '0;
      spec_o = 1'b0;
    end
    spec_val_o = spec_full[FIELD_W-1:0];
    swap = (exa < exb) || ((exa == exb) && (siga < sigb));
    exx = swap ? exb : exa;
    exy = swap ? exa : exb;
    sx  = swap ? sigb : siga;
    sy  = swap ? siga : sigb;
    sign_o = swap ? sb : sa;
    sub_o = sa != sb;
    de = exx - exy;
    xs_o = {sx, 3'b000};
    yss = {sy, 3'b000};
    ex_o = EW'(exx);
    lostm = '0;
    if (32'(de) > FRAC_W + 4) ys_o = SW'(1);
    else begin
      lostm = ~(SW'('1) << de);
      ys_o = (yss >> de) | SW'((yss & lostm) != '0);
    end
  end
endmodule

// File: design/mfa_addnorm.sv
// Stage 2: add or subtract, carry fix, leading-zero count.
module mfa_addnorm import mfa_pkg::*; #(
  parameter int unsigned EXP_W  = EXP_W_DEF,
  parameter int unsigned FRAC_W = FRAC_W_DEF,
  localparam int unsigned SW = FRAC_W + 4,
  localparam int unsigned EW = (EXP_W + 2 > $clog2(SW) + 1) ? EXP_W + 2 : $clog2(SW) + 1
) (
  input  logic          sub_i,
  input  logic [EW-1:0] ex_i,
  input  logic [SW-1:0] xs_i,
  input  logic [SW-1:0] ys_i,
  output logic          zero_o,
  output logic [EW-1:0] ex_o,
  output logic [SW-1:0] rs_o,
  output logic [EW-1:0] lz_o
);
  logic [SW:0] r;
  logic [SW-1:0] rs;
  logic found;
  always_comb begin
    r = sub_i ? ({1'b0, xs_i} - {1'b0, ys_i}) : ({1'b0, xs_i} + {1'b0, ys_i});
    zero_o = (r == '0);
    if (r[SW]) begin
      rs = r[SW:1] | SW'(r[0]);
      ex_o = ex_i + EW'(1);
    end else begin
      rs = r[SW-1:0];
      ex_o = ex_i;
    end
    rs_o = rs;
    lz_o = '0;
    found = 1'b0;
    for (int i = SW - 2; i >= 0; i--) begin
      if (!found && !rs[i+1]) lz_o = lz_o + EW'(1);
      else found = 1'b1;
    end
  end
endmodule

// File: design/mfa_round.sv
// Stage 3: normalize shift, round to nearest even, pack.
module mfa_round import mfa_pkg::*; #(
  parameter int unsigned EXP_W  = EXP_W_DEF,
  parameter int unsigned FRAC_W = FRAC_W_DEF,
  localparam int unsigned SW = FRAC_W + 4,
  localparam int unsigned EW = (EXP_W + 2 > $clog2(SW) + 1) ? EXP_W + 2 : $clog2(SW) + 1
) (
  input  logic               sign_i,
  input  logic               zero_i,
  input  logic [EW-1:0]      ex_i,
  input  logic [SW-1:0]      rs_i,
  input  logic [EW-1:0]      lz_i,
  output logic [FIELD_W-1:0] sum_o
);
  localparam int unsigned FMT = 1 + EXP_W + FRAC_W;
  localparam int unsigned FW  = (FMT > FIELD_W) ? FMT : FIELD_W;
  logic [EW-1:0] sh, ex;
  logic [SW-1:0] rs;
  logic [FRAC_W+1:0] sig;
  logic [FW-1:0] w;
  always_comb begin
    sh = (ex_i - EW'(1) < lz_i) ? ex_i - EW'(1) : lz_i;
    rs = rs_i << sh;
    ex = ex_i - sh;
    sig = {1'b0, rs[SW-1:3]};
    if (rs[2] && (rs[1] || rs[0] || sig[0])) begin
      sig = sig + 1'b1;
      if (sig[FRAC_W+1]) begin
        sig = sig >> 1;
        ex = ex + EW'(1);
      end
    end
    w = '0;
    if (zero_i) w = '0;
    else if (ex >= EW'({EXP_W{1'b1}})) begin
      w[FRAC_W +: EXP_W] = '1;
      w[FMT-1] = sign_i;
    end else begin
      w[FRAC_W-1:0] = sig[FRAC_W-1:0];
      w[FRAC_W +: EXP_W] = sig[FRAC_W] ? ex[EXP_W-1:0] : '0;
      w[FMT-1] = sign_i;
    end
    sum_o = w[FIELD_W-1:0];
  end
endmodule

// File: design/minifloat_adder_rne.sv
// Top level: three-stage pipelined minifloat adder with round to nearest even.
// Usage:
//   Input channel: operand_a_i/operand_b_i with in_valid_i; a beat is taken
//   when in_valid_i is high and in_stall_o is low.
//   Output channel: sum_o with out_valid_o; a beat leaves when out_valid_o is
//   high and out_stall_i is low.
//   Throughput: one beat per cycle while out_stall_i is low;
//   stages are align, add/leading-zero count, normalize/round, each
//   behind its own register.
//   Stall: out_stall_i holds the output register; empty stages still fill,
//   and in_stall_o rises only once all three stages hold beats, so no beat
//   is lost or repeated.
//   Reset: rst_ni clears all valid bits; the pipe is then empty.
//   Special values: NaN or opposite infinities give +qNaN, a zero operand
//   returns the other unchanged, exact cancellation gives +0.
module minifloat_adder_rne import mfa_pkg::*; #(
  parameter int unsigned EXP_W  = EXP_W_DEF,
  parameter int unsigned FRAC_W = FRAC_W_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FIELD_W-1:0] operand_a_i,
  input  logic [FIELD_W-1:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FIELD_W-1:0] sum_o
);
  localparam int unsigned SW = FRAC_W + 4;
  localparam int unsigned EW = (EXP_W + 2 > $clog2(SW) + 1) ? EXP_W + 2 : $clog2(SW) + 1;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic s1_spec_d, s1_sub_d, s1_sign_d;
  logic [FIELD_W-1:0] s1_sval_d;
  logic [EW-1:0] s1_ex_d;
  logic [SW-1:0] s1_xs_d, s1_ys_d;
  logic s1_spec_q, s1_sub_q, s1_sign_q;
  logic [FIELD_W-1:0] s1_sval_q;
  logic [EW-1:0] s1_ex_q;
  logic [SW-1:0] s1_xs_q, s1_ys_q;
  logic s2_zero_d;
  logic [EW-1:0] s2_ex_d, s2_lz_d;
  logic [SW-1:0] s2_rs_d;
  logic s2_spec_q, s2_sign_q, s2_zero_q;
  logic [FIELD_W-1:0] s2_sval_q;
  logic [EW-1:0] s2_ex_q, s2_lz_q;
  logic [SW-1:0] s2_rs_q;
  logic [FIELD_W-1:0] s3_sum_d, sum_q;

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;
  assign out_valid_o = v3_q;
  assign sum_o = sum_q;

  mfa_align #(.EXP_W(EXP_W), .FRAC_W(FRAC_W)) u_align (
    .a_i(operand_a_i), .b_i(operand_b_i), .spec_o(s1_spec_d), .spec_val_o(s1_sval_d),
    .sub_o(s1_sub_d), .sign_o(s1_sign_d), .ex_o(s1_ex_d), .xs_o(s1_xs_d), .ys_o(s1_ys_d)
  );
  mfa_addnorm #(.EXP_W(EXP_W), .FRAC_W(FRAC_W)) u_add (
    .sub_i(s1_sub_q), .ex_i(s1_ex_q), .xs_i(s1_xs_q), .ys_i(s1_ys_q),
    .zero_o(s2_zero_d), .ex_o(s2_ex_d), .rs_o(s2_rs_d), .lz_o(s2_lz_d)
  );
  mfa_round #(.EXP_W(EXP_W), .FRAC_W(FRAC_W)) u_round (
    .sign_i(s2_sign_q), .zero_i(s2_zero_q), .ex_i(s2_ex_q), .rs_i(s2_rs_q),
    .lz_i(s2_lz_q), .sum_o(s3_sum_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_spec_q <= s1_spec_d;
      s1_sval_q <= s1_sval_d;
      s1_sub_q  <= s1_sub_d;
      s1_sign_q <= s1_sign_d;
      s1_ex_q   <= s1_ex_d;
      s1_xs_q   <= s1_xs_d;
      s1_ys_q   <= s1_ys_d;
    end
    if (en2 && v1_q) begin
      s2_spec_q <= s1_spec_q;
      s2_sval_q <= s1_sval_q;
      s2_sign_q <= s1_sign_q;
      s2_zero_q <= s2_zero_d;
      s2_ex_q   <= s2_ex_d;
      s2_rs_q   <= s2_rs_d;
      s2_lz_q   <= s2_lz_d;
    end
    if (en3 && v2_q) sum_q <= s2_spec_q ? s2_sval_q : s3_sum_d;
  end
endmodule

// File: verif/tb_minifloat_adder_rne.sv
// Testbench: random and directed operand pairs checked against a bit-true adder model.
`timescale 1ns / 1ps
module tb_minifloat_adder_rne;
  import mfa_pkg::*;

  localparam int EB = 8;
  localparam int MB = 13;
  localparam logic [FIELD_W-1:0] QNAN = {1'b0, {EB{1'b1}}, 1'b1, {(MB-1){1'b0}}};
  localparam logic [FIELD_W-1:0] PINF = {1'b0, {EB{1'b1}}, {MB{1'b0}}};
  localparam logic [FIELD_W-1:0] SGN  = {1'b1, {(FIELD_W-1){1'b0}}};

  typedef struct packed {
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
  } pair_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic out_stall_i = 0;
  logic [FIELD_W-1:0] operand_a_i = '0;
  logic [FIELD_W-1:0] operand_b_i = '0;
  logic in_stall_o, out_valid_o;
  logic [FIELD_W-1:0] sum_o;

  minifloat_adder_rne dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  pair_t pending_q[$];
  logic [FIELD_W-1:0] sum_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int errors = 0;
  int n_sums = 0;

  function automatic logic [FIELD_W-1:0] fp_add(logic [FIELD_W-1:0] aw, logic [FIELD_W-1:0] bw);
    logic xsn, ysn, xz, yz, xi, yi, xn, yn, sn, g, r, s, t;
    logic [EB-1:0] xe, ye;
    int xex, yex, de, ex;
    logic [63:0] xsig, ysig, xs, ys, rs, sig, tmp;
    xsn = aw[FIELD_W-1]; ysn = bw[FIELD_W-1];
    xe = aw[MB+:EB]; ye = bw[MB+:EB];
    xz = xe == 0 && aw[MB-1:0] == 0; yz = ye == 0 && bw[MB-1:0] == 0;
    xi = &xe && aw[MB-1:0] == 0; yi = &ye && bw[MB-1:0] == 0;
    xn = &xe && aw[MB-1:0] != 0; yn = &ye && bw[MB-1:0] != 0;
    xex = xe == 0 ? 1 : xe; yex = ye == 0 ? 1 : ye;
    xsig = {50'd0, xe != 0, aw[MB-1:0]};
    ysig = {50'd0, ye != 0, bw[MB-1:0]};
    if (xn || yn) return QNAN;
    if (xi && yi && xsn != ysn) return QNAN;
    if (xi) return PINF | (FIELD_W'(xsn) << (FIELD_W-1));
    if (yi) return PINF | (FIELD_W'(ysn) << (FIELD_W-1));
    if (xz) return bw;
    if (yz) return aw;
    if (xex < yex || (xex == yex && xsig < ysig)) begin
      t = xsn; xsn = ysn; ysn = t;
      de = xex; xex = yex; yex = de;
      tmp = xsig; xsig = ysig; ysig = tmp;
    end
    de = xex - yex;
    xs = xsig << 3; ys = ysig << 3;
    if (de > MB + 4) ys = 1;
    else begin
      tmp = ys & ((64'd1 << de) - 1);
      ys = ys >> de;
      if (tmp != 0) ys[0] = 1'b1;
    end
    ex = xex;
    if (xsn == ysn) begin rs = xs + ys; sn = xsn; end
    else if (xs >= ys) begin rs = xs - ys; sn = xsn; end
    else begin rs = ys - xs; sn = ysn; end
    if (rs == 0) return '0;
    if (rs >= (64'd1 << (MB + 4))) begin
      rs = (rs >> 1) | (rs & 1);
      ex++;
    end
    while (rs < (64'd1 << (MB + 3)) && ex > 1) begin
      rs <<= 1;
      ex--;
    end
    sig = rs >> 3; g = rs[2]; r = rs[1]; s = rs[0];
    if (g && (r || s || sig[0])) begin
      sig++;
      if (sig == (64'd1 << (MB + 1))) begin
        sig >>= 1;
        ex++;
      end
    end
    if (ex >= (1 << EB) - 1) return PINF | (FIELD_W'(sn) << (FIELD_W-1));
    if (sig < (64'd1 << MB)) ex = 0;
    return {sn, EB'(ex), sig[MB-1:0]};
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sum_q.push_back(fp_add(operand_a_i, operand_b_i));
        void'(pending_q.pop_front());
      end
      if ((!in_valid_i || !in_stall_o)) begin
        if (in_valid_i && !in_stall_o) begin
          if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            operand_a_i <= pending_q[0].a;
            operand_b_i <= pending_q[0].b;
            in_valid_i <= 1;
          end else in_valid_i <= 0;
        end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          operand_a_i <= pending_q[0].a;
          operand_b_i <= pending_q[0].b;
          in_valid_i <= 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_sums++;
        if (sum_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat: sum %h", sum_o);
        end else begin
          if (sum_o !== sum_q[0]) begin
            errors++;
            if (errors <= 10) $display("sum mismatch: exp %h got %h", sum_q[0], sum_o);
          end
          void'(sum_q.pop_front());
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        out_stall_i <= 1;
        hold_cycles <= hold_cycles - 1;
      end else out_stall_i <= $urandom_range(99) < recv_stall_pct;
    end
  end

  function automatic logic [FIELD_W-1:0] rand_word();
    logic [FIELD_W-1:0] w;
    w = FIELD_W'($urandom);
    case ($urandom_range(9))
      0: w[MB+:EB] = '0;
      1: w[MB+:EB] = '1;
      2: w[MB+:EB] = EB'($urandom_range(253, 250));
      3: w[MB-1:0] = $urandom_range(1) ? '1 : '0;
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_pair(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
    pair_t p;
    p.a = a; p.b = b;
    pending_q.push_back(p);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || sum_q.size() > 0 || in_valid_i) @(posedge clk_i);
  endtask

  initial begin
    logic [FIELD_W-1:0] w, big, one;
    big = {1'b0, EB'(254), {MB{1'b1}}};
    one = {1'b0, EB'(127), {MB{1'b0}}};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    add_pair(QNAN, one);
    add_pair(one, QNAN | 22'h1);
    add_pair(PINF, PINF | SGN);
    add_pair(PINF, one);
    add_pair(one, PINF | SGN);
    add_pair(PINF, PINF);
    add_pair('0, one | SGN);
    add_pair(SGN, '0);
    add_pair(one, '0);
    add_pair(one, one | SGN);
    add_pair(big, big);
    add_pair(big, {1'b0, EB'(230), {MB{1'b0}}});
    add_pair(one, 22'h1);
    add_pair(22'h1, 22'h1);
    add_pair({1'b0, {EB{1'b0}}, {MB{1'b1}}}, 22'h1);
    add_pair({1'b0, {EB{1'b0}}, {MB{1'b1}}}, 22'h1 | SGN);
    add_pair(one, {1'b0, EB'(113), {MB{1'b0}}});
    add_pair(one, {1'b0, EB'(113), 13'h1});
    add_pair(one | 22'h1, {1'b0, EB'(113), {MB{1'b0}}});
    add_pair(one | 22'h1, {1'b1, EB'(126), {MB{1'b1}}});
    add_pair('1, '1);
    add_pair(22'h3FDFFF, 22'h1FDFFF);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 57; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 57; end
        3: begin send_idle_pct = 31; recv_stall_pct = 31; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 60; end
      endcase
      for (int i = 0; i < 205; i++) begin
        w = rand_word();
        case ($urandom_range(3))
          0: add_pair(w, rand_word());
          1: add_pair(w, {~w[FIELD_W-1], w[FIELD_W-2:0]} ^ FIELD_W'($urandom_range(3)));
          2: add_pair(w, {$urandom_range(1) ? 1'b1 : 1'b0,
                          w[MB+:EB] - EB'($urandom_range(MB + 6)), MB'($urandom)});
          default: add_pair(w, w ^ FIELD_W'($urandom_range(255)));
        endcase
      end
      drain();
    end
    repeat (10) @(posedge clk_i);
    $display("Checked %0d sums over 1047 operand pairs: specials, subnormals, overflow,",
             n_sums);
    $display("cancellation, and five handshake pacing phases including a long output hold.");
    if (errors == 0 && sum_q.size() == 0) $display("minifloat_adder_rne: match");
    else $display("minifloat_adder_rne: mismatch");
    $finish;
  end

  initial begin
    #2ms;
    $display("minifloat_adder_rne: mismatch");
    $finish;
  end
endmodule

// File: sim.f
design/mfa_pkg.sv
design/mfa_align.sv
design/mfa_addnorm.sv
design/mfa_round.sv
design/minifloat_adder_rne.sv
verif/tb_minifloat_adder_rne.sv
